/* hw/rtl/hmtm_pkg.sv */
// Shared types, constants and small tables for the heightmap tile mesher.
// No dependencies; every other file of the block imports this package.
package hmtm_pkg;

  localparam int MAP_SIZE_DEF = 128;
  localparam int HW = 10;
  localparam int NW = 16;

  localparam logic [7:0] MAP_WIDTH_RST = 8'd128;
  localparam logic [6:0] TILE_SIZE_RST = 7'd1;

  typedef enum logic {
    CFG_MAP_WIDTH = 1'b0,
    CFG_TILE_SIZE = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_TILE = 1'b1
  } mode_e;

  typedef struct packed {
    logic [7:0]    x;
    logic [7:0]    z;
    logic [6:0]    t;
    logic [HW-1:0] s00;
    logic [HW-1:0] s10;
    logic [HW-1:0] s11;
    logic [HW-1:0] s01;
    logic          oor;
  } tile_t;

  typedef struct packed {
    logic signed [NW-1:0] x;
    logic signed [NW-1:0] y;
    logic signed [NW-1:0] z;
  } nrm_t;

  typedef struct packed {
    tile_t tile;
    nrm_t  na;
    nrm_t  nb;
  } mesh_t;

  function automatic logic tex_u(input logic [2:0] k);
    return (k == 3'd1) || (k == 3'd2) || (k == 3'd3);
  endfunction

  function automatic logic tex_v(input logic [2:0] k);
    return (k == 3'd2) || (k == 3'd3) || (k == 3'd4);
  endfunction

endpackage

/* hw/rtl/hmtm_fetch.sv */
// Input side of the mesher: holds the height store, writes loaded pixels,
// computes tile geometry and reads the four corner heights. Uses hmtm_pkg.
module hmtm_fetch #(
  parameter int MAP_SIZE = hmtm_pkg::MAP_SIZE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [6:0]         row_i,
  input  logic [6:0]         col_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  input  logic [7:0]         map_width_i,
  input  logic [6:0]         tile_size_i,
  output logic               tile_valid_o,
  input  logic               tile_ready_i,
  output hmtm_pkg::tile_t    tile_o
);
  import hmtm_pkg::*;

  localparam int AW = $clog2(MAP_SIZE * MAP_SIZE);
  localparam logic signed [15:0] MS = 16'(MAP_SIZE);

  typedef enum logic [2:0] {F_IDLE, F_GEOM, F_READ, F_LAST, F_HAND} fst_e;

  fst_e                st_q;
  logic [13:0]         xm_q, zm_q;
  logic [6:0]          t_q;
  logic [7:0]          w_q;
  logic signed [15:0]  x_q, z_q;
  logic                oor_q;
  logic [1:0]          cnt_q;
  logic                rd_pend_q;
  logic [1:0]          rd_idx_q;
  logic [HW-1:0]       s_q [4];
  logic [HW-1:0]       mem_q [MAP_SIZE * MAP_SIZE];
  logic [HW-1:0]       rdata_q;

  logic                accept;
  logic                mem_we;
  logic [AW-1:0]       mem_addr;
  logic [HW-1:0]       wdata;
  logic signed [15:0]  xa, za, ts, ws;
  logic                ok;

  assign in_ready_o = (st_q == F_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign mem_we     = accept && (mode_i == MODE_LOAD) &&
                      (32'(row_i) < 32'(MAP_SIZE)) && (32'(col_i) < 32'(MAP_SIZE));
  assign wdata      = HW'(red_i) + HW'(green_i) + HW'(blue_i);

  always_comb begin
    logic signed [15:0] cx, cz;
    cx = x_q + (((cnt_q == 2'd1) || (cnt_q == 2'd2)) ? ts : 16'sd0);
    cz = z_q + (cnt_q[1] ? ts : 16'sd0);
    if (st_q == F_READ) begin
      mem_addr = AW'(cx) * AW'(MAP_SIZE) + AW'(cz);
    end else begin
      mem_addr = AW'(row_i) * AW'(MAP_SIZE) + AW'(col_i);
    end
  end

  always_comb begin
    logic signed [15:0] xs, zs;
    ts = signed'({9'd0, t_q});
    ws = signed'({8'd0, w_q});
    xs = signed'({2'd0, xm_q});
    zs = signed'({2'd0, zm_q});
    xa = (xs == ws - ts) ? xs - ts : xs;
    za = (zs == ws - ts) ? zs - ts : zs;
    ok = (t_q != 7'd0) && (xa >= 16'sd0) && (za >= 16'sd0) &&
         (xa + ts <= ws - 16'sd1) && (za + ts <= ws - 16'sd1) &&
         (xa + ts < MS) && (za + ts < MS);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= wdata;
    end
    rdata_q <= mem_q[mem_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      xm_q <= 14'(col_i) * 14'(tile_size_i);
      zm_q <= 14'(row_i) * 14'(tile_size_i);
      t_q  <= tile_size_i;
      w_q  <= map_width_i;
    end
    if (st_q == F_GEOM) begin
      x_q   <= xa;
      z_q   <= za;
      oor_q <= !ok;
    end
    if (rd_pend_q) begin
      s_q[rd_idx_q] <= rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= F_IDLE;
      cnt_q     <= 2'd0;
      rd_pend_q <= 1'b0;
      rd_idx_q  <= 2'd0;
    end else begin
      rd_pend_q <= (st_q == F_READ);
      rd_idx_q  <= cnt_q;
      unique case (st_q)
        F_IDLE: begin
          if (accept && (mode_i == MODE_TILE)) begin
            st_q <= F_GEOM;
          end
        end
        F_GEOM: begin
          cnt_q <= 2'd0;
          st_q  <= ok ? F_READ : F_HAND;
        end
        F_READ: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            st_q <= F_LAST;
          end
        end
        F_LAST: begin
          st_q <= F_HAND;
        end
        F_HAND: begin
          if (tile_ready_i) begin
            st_q <= F_IDLE;
          end
        end
        default: st_q <= F_IDLE;
      endcase
    end
  end

  assign tile_valid_o = (st_q == F_HAND);
  assign tile_o.x     = x_q[7:0];
  assign tile_o.z     = z_q[7:0];
  assign tile_o.t     = t_q;
  assign tile_o.s00   = s_q[0];
  assign tile_o.s10   = s_q[1];
  assign tile_o.s11   = s_q[2];
  assign tile_o.s01   = s_q[3];
  assign tile_o.oor   = oor_q;

endmodule

/* hw/rtl/hmtm_nunit.sv */
// One normal component: finds the rounded Q1.15 value of v / sqrt(L) by a
// bit-serial search over the odd divisor candidate. Uses hmtm_pkg.
module hmtm_nunit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [22:0]                   len_i,
  input  logic [21:0]                   msq_i,
  input  logic                          neg_i,
  output logic                          busy_o,
  output logic signed [hmtm_pkg::NW-1:0] comp_o
);
  import hmtm_pkg::*;

  localparam int PW = 58;

  logic          busy_q, first_q, zero_q, neg_q;
  logic [3:0]    k_q;
  logic [PW-1:0] p_q, qs_q, ls_q, m_q;
  logic [15:0]   d_q;
  logic [PW-1:0] cand;
  logic [15:0]   lo;

  assign cand = p_q + qs_q + ls_q;
  assign lo   = {1'b0, d_q[15:1]} + 16'd1;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q   <= PW'(len_i);
      qs_q  <= PW'(len_i) << 16;
      ls_q  <= PW'(len_i) << 30;
      m_q   <= PW'(msq_i) << 32;
      d_q   <= 16'd0;
      k_q   <= 4'd15;
      zero_q <= 1'b0;
      neg_q <= neg_i;
    end else if (busy_q && first_q) begin
      zero_q <= (p_q > m_q);
    end else if (busy_q) begin
      if (cand <= m_q) begin
        p_q      <= cand;
        qs_q     <= (qs_q + (ls_q << 1)) >> 1;
        d_q[k_q] <= 1'b1;
      end else begin
        qs_q <= qs_q >> 1;
      end
      ls_q <= ls_q >> 2;
      k_q  <= k_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      first_q <= 1'b1;
    end else if (busy_q && first_q) begin
      first_q <= 1'b0;
      busy_q  <= !(p_q > m_q);
    end else if (busy_q && (k_q == 4'd1)) begin
      busy_q <= 1'b0;
    end
  end

  always_comb begin
    if (zero_q) begin
      comp_o = '0;
    end else if (neg_q) begin
      comp_o = signed'(16'd0 - lo);
    end else if (lo[15]) begin
      comp_o = 16'sd32767;
    end else begin
      comp_o = signed'(lo);
    end
  end

  assign busy_o = busy_q;

endmodule

/* hw/rtl/hmtm_normals.sv */
// Face normal engine: height differences, squared lengths and six component
// units running in parallel. Uses hmtm_pkg and hmtm_nunit.
module hmtm_normals (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tile_valid_i,
  output logic             tile_ready_o,
  input  hmtm_pkg::tile_t  tile_i,
  output logic             mesh_valid_o,
  input  logic             mesh_ready_i,
  output hmtm_pkg::mesh_t  mesh_o
);
  import hmtm_pkg::*;

  typedef enum logic [2:0] {N_IDLE, N_SQ, N_LEN, N_RUN, N_DONE} nst_e;

  nst_e               st_q;
  tile_t              tile_q;
  logic signed [10:0] d_q [4];
  logic [10:0]        tt_q;
  logic [21:0]        sq_q [5];
  logic [22:0]        len_a_q, len_b_q;
  logic               start_q;
  logic [5:0]         busy;
  logic signed [NW-1:0] comp [6];
  logic [22:0]        u_len [6];
  logic [21:0]        u_msq [6];
  logic               u_neg [6];

  assign tile_ready_o = (st_q == N_IDLE);

  // Lanes: A x, A y, A z, B x, B y, B z.
  assign u_len[0] = len_a_q;
  assign u_len[1] = len_a_q;
  assign u_len[2] = len_a_q;
  assign u_len[3] = len_b_q;
  assign u_len[4] = len_b_q;
  assign u_len[5] = len_b_q;
  assign u_msq[0] = sq_q[0];
  assign u_msq[1] = sq_q[4];
  assign u_msq[2] = sq_q[1];
  assign u_msq[3] = sq_q[2];
  assign u_msq[4] = sq_q[4];
  assign u_msq[5] = sq_q[3];
  assign u_neg[0] = d_q[0][10];
  assign u_neg[1] = 1'b0;
  assign u_neg[2] = d_q[1][10];
  assign u_neg[3] = d_q[2][10];
  assign u_neg[4] = 1'b0;
  assign u_neg[5] = d_q[3][10];

  for (genvar i = 0; i < 6; i++) begin : g_unit
    hmtm_nunit u_nunit (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (start_q),
      .len_i   (u_len[i]),
      .msq_i   (u_msq[i]),
      .neg_i   (u_neg[i]),
      .busy_o  (busy[i]),
      .comp_o  (comp[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (tile_valid_i && tile_ready_o) begin
      tile_q <= tile_i;
      d_q[0] <= signed'(11'(tile_i.s00)) - signed'(11'(tile_i.s10));
      d_q[1] <= signed'(11'(tile_i.s10)) - signed'(11'(tile_i.s11));
      d_q[2] <= signed'(11'(tile_i.s01)) - signed'(11'(tile_i.s11));
      d_q[3] <= signed'(11'(tile_i.s00)) - signed'(11'(tile_i.s01));
      tt_q   <= 11'(tile_i.t) * 11'd15;
    end
    if (st_q == N_SQ) begin
      for (int i = 0; i < 4; i++) begin
        sq_q[i] <= 22'(d_q[i] * d_q[i]);
      end
      sq_q[4] <= 22'(tt_q) * 22'(tt_q);
    end
    if (st_q == N_LEN) begin
      len_a_q <= 23'(sq_q[0]) + 23'(sq_q[4]) + 23'(sq_q[1]);
      len_b_q <= 23'(sq_q[2]) + 23'(sq_q[4]) + 23'(sq_q[3]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= N_IDLE;
      start_q <= 1'b0;
    end else begin
      start_q <= (st_q == N_LEN);
      unique case (st_q)
        N_IDLE: if (tile_valid_i) begin
          st_q <= N_SQ;
        end
        N_SQ:  st_q <= N_LEN;
        N_LEN: st_q <= N_RUN;
        N_RUN: if (!start_q && (busy == 6'd0)) begin
          st_q <= N_DONE;
        end
        N_DONE: if (mesh_ready_i) begin
          st_q <= N_IDLE;
        end
        default: st_q <= N_IDLE;
      endcase
    end
  end

  assign mesh_valid_o = (st_q == N_DONE);
  assign mesh_o.tile  = tile_q;
  assign mesh_o.na.x  = comp[0];
  assign mesh_o.na.y  = comp[1];
  assign mesh_o.na.z  = comp[2];
  assign mesh_o.nb.x  = comp[3];
  assign mesh_o.nb.y  = comp[4];
  assign mesh_o.nb.z  = comp[5];

endmodule

/* hw/rtl/heightmap_tile_mesher.sv */
// Top level of the heightmap tile mesher: configuration registers, fetch
// stage, normal engine and vertex emitter. Uses hmtm_pkg, hmtm_fetch, hmtm_normals.
//
// Usage: the input channel carries load beats (mode 0) that write r+g+b into
// the height store at row*MAP_SIZE+col, and tile beats (mode 1) that request
// one tile. A load beat gives no output. A tile beat gives six output beats,
// two triangles with positions, texture corners and Q1.15 face normals;
// last_vertex marks the sixth. A tile outside the map gives six beats with
// out_of_range set and zero positions, heights, normals. Three tiles overlap
// in fetch, normal engine and emitter; the sustained rate is set by the normal
// engine: squares, lengths, a start, a zero check, 15 search steps, a
// completion check and the hand-over. Each tile holds input ready low while
// it reads corners, longer while the normal engine is busy. When the receiver
// stalls, the emitter holds its beat, then the normal engine and fetch stage
// fill and input ready drops. Reset sets map_width to 128 and tile_size to 1;
// the height store is undefined until loaded. The user must write
// configuration only while the block is idle; the block does not enforce it.
module heightmap_tile_mesher #(
  parameter int MAP_SIZE = hmtm_pkg::MAP_SIZE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [7:0]                       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             mode_i,
  input  logic [6:0]                       row_i,
  input  logic [6:0]                       col_i,
  input  logic [7:0]                       red_i,
  input  logic [7:0]                       green_i,
  input  logic [7:0]                       blue_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [7:0]                       pos_x_o,
  output logic [7:0]                       pos_z_o,
  output logic [hmtm_pkg::HW-1:0]          height_sum_o,
  output logic signed [hmtm_pkg::NW-1:0]   normal_x_o,
  output logic signed [hmtm_pkg::NW-1:0]   normal_y_o,
  output logic signed [hmtm_pkg::NW-1:0]   normal_z_o,
  output logic                             tex_u_o,
  output logic                             tex_v_o,
  output logic                             last_vertex_o,
  output logic                             out_of_range_o
);
  import hmtm_pkg::*;

  logic [7:0]  map_width_q;
  logic [6:0]  tile_size_q;
  logic        tile_valid, tile_ready;
  tile_t       tile;
  logic        mesh_valid, mesh_ready;
  mesh_t       mesh;
  mesh_t       rec_q;
  logic        em_busy_q;
  logic [2:0]  vcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q <= MAP_WIDTH_RST;
      tile_size_q <= TILE_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MAP_WIDTH: map_width_q <= cfg_data_i;
        CFG_TILE_SIZE: tile_size_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  hmtm_fetch #(.MAP_SIZE(MAP_SIZE)) u_fetch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .map_width_i  (map_width_q),
    .tile_size_i  (tile_size_q),
    .tile_valid_o (tile_valid),
    .tile_ready_i (tile_ready),
    .tile_o       (tile)
  );

  hmtm_normals u_normals (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tile_valid_i (tile_valid),
    .tile_ready_o (tile_ready),
    .tile_i       (tile),
    .mesh_valid_o (mesh_valid),
    .mesh_ready_i (mesh_ready),
    .mesh_o       (mesh)
  );

  assign mesh_ready = !em_busy_q;

  always_ff @(posedge clk_i) begin
    if (mesh_valid && mesh_ready) begin
      rec_q <= mesh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_busy_q <= 1'b0;
      vcnt_q    <= 3'd0;
    end else if (!em_busy_q) begin
      if (mesh_valid) begin
        em_busy_q <= 1'b1;
        vcnt_q    <= 3'd0;
      end
    end else if (out_ready_i) begin
      vcnt_q <= vcnt_q + 3'd1;
      if (vcnt_q == 3'd5) begin
        em_busy_q <= 1'b0;
      end
    end
  end

  always_comb begin
    logic add_x, add_z;
    logic [HW-1:0] hs;
    add_x = 1'b0;
    add_z = 1'b0;
    hs    = rec_q.tile.s00;
    unique case (vcnt_q)
      3'd0: begin add_x = 1'b1; add_z = 1'b1; hs = rec_q.tile.s11; end
      3'd1: begin add_x = 1'b1; hs = rec_q.tile.s10; end
      3'd2, 3'd3: hs = rec_q.tile.s00;
      3'd4: begin add_z = 1'b1; hs = rec_q.tile.s01; end
      3'd5: begin add_x = 1'b1; add_z = 1'b1; hs = rec_q.tile.s11; end
      default: ;
    endcase
    if (rec_q.tile.oor) begin
      pos_x_o      = '0;
      pos_z_o      = '0;
      height_sum_o = '0;
      normal_x_o   = '0;
      normal_y_o   = '0;
      normal_z_o   = '0;
    end else begin
      pos_x_o      = rec_q.tile.x + (add_x ? 8'(rec_q.tile.t) : 8'd0);
      pos_z_o      = rec_q.tile.z + (add_z ? 8'(rec_q.tile.t) : 8'd0);
      height_sum_o = hs;
      normal_x_o   = (vcnt_q < 3'd3) ? rec_q.na.x : rec_q.nb.x;
      normal_y_o   = (vcnt_q < 3'd3) ? rec_q.na.y : rec_q.nb.y;
      normal_z_o   = (vcnt_q < 3'd3) ? rec_q.na.z : rec_q.nb.z;
    end
  end

  assign out_valid_o    = em_busy_q;
  assign tex_u_o        = tex_u(vcnt_q);
  assign tex_v_o        = tex_v(vcnt_q);
  assign last_vertex_o  = (vcnt_q == 3'd5);
  assign out_of_range_o = rec_q.tile.oor;

endmodule
